[design/mwg_pkg.sv]
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared constants and codes of the multi-waveform generator.
// ----------------------------------------------------------------------------
package mwg_pkg;

  localparam int PHASE_BITS_DEF     = 32;
  localparam int SINE_ADDR_BITS_DEF = 10;
  localparam int AMP_FRAC_BITS_DEF  = 16;

  // Wave values are carried as magnitudes in Q30, so one is 2^30.
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic [30:0] FS_8  = 31'd127;
  localparam logic [30:0] FS_16 = 31'd32767;
  localparam logic [30:0] FS_32 = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_32 = 2'd2;

  localparam logic [2:0] REG_WAVE   = 3'd0;
  localparam logic [2:0] REG_STEP   = 3'd1;
  localparam logic [2:0] REG_AMP    = 3'd2;
  localparam logic [2:0] REG_DEPTH  = 3'd3;
  localparam logic [2:0] REG_TOTAL  = 3'd4;

endpackage

[design/mwg_sine_rom.sv]
// ----------------------------------------------------------------------------
// mwg_sine_rom
// Quarter-wave sine table in Q30 with a registered read port.
// ----------------------------------------------------------------------------
module mwg_sine_rom #(
  parameter int SINE_ADDR_BITS = mwg_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rd_en,
  input  logic [SINE_ADDR_BITS:0] rd_idx,
  output logic [30:0]             rd_data
);

  localparam int TAB_N = 1 << SINE_ADDR_BITS;

  typedef logic [30:0] tab_t [TAB_N+1];

  // Truncated Taylor series of sin(x), x in Q30, clamped to [0, 1].
  // The odd powers x^3 .. x^17 alternate in sign; term n is divided by (2n)(2n+1).
  function automatic logic [30:0] sine_q30(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + signed'(term);
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - signed'(term);
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + signed'(term);
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > signed'(64'(mwg_pkg::ONE_Q30))) begin
      sum = signed'(64'(mwg_pkg::ONE_Q30));
    end
    return 31'(sum);
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    for (int k = 0; k <= TAB_N; k++) begin
      t[k] = sine_q30((64'(k) * mwg_pkg::HALF_PI_Q30) >> SINE_ADDR_BITS);
    end
    return t;
  endfunction

  localparam tab_t SINE_TAB = build_tab();

  logic [30:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= SINE_TAB[rd_idx];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/multi_waveform_generator_top.sv]
// ----------------------------------------------------------------------------
// multi_waveform_generator_top
// Direct digital synthesis generator of sine, sawtooth, square and triangle.
// ----------------------------------------------------------------------------
// Each accepted transaction is one tick. While the run is not finished the tick
// yields one PCM sample and advances the phase accumulator; once total_samples
// samples have been produced, ticks yield nothing until a tick with restart set.
// A new tick can be accepted in every clock cycle unless the output stalls and
// the pipeline has filled: the phase update is a single add, and the sample
// path is a five-register pipeline (phase capture, sine table read, amplitude
// multiply, full-scale multiply, output register), and while the output is
// taken samples follow at one per cycle. Stages move independently, so ticks
// are still accepted while a sample waits in the output register, as long as an
// earlier stage is free.
// The user must write registers through the APB port only while no sample is in flight; the block does not enforce it.
module multi_waveform_generator_top #(
  parameter int PHASE_BITS     = mwg_pkg::PHASE_BITS_DEF,
  parameter int SINE_ADDR_BITS = mwg_pkg::SINE_ADDR_BITS_DEF,
  parameter int AMP_FRAC_BITS  = mwg_pkg::AMP_FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_restart,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_sample,
  output logic        out_last,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TAB_N = 1 << SINE_ADDR_BITS;

  // Configuration registers.
  mwg_pkg::wave_t wave_select_r;
  logic [31:0]    phase_step_r;
  logic [17:0]    amplitude_r;
  logic [1:0]     depth_mode_r;
  logic [31:0]    total_samples_r;

  logic           cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_select_r   <= mwg_pkg::WAVE_SINE;
      phase_step_r    <= '0;
      amplitude_r     <= 18'd65536;
      depth_mode_r    <= mwg_pkg::DEPTH_16;
      total_samples_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        mwg_pkg::REG_WAVE:  wave_select_r   <= mwg_pkg::wave_t'(pwdata[1:0]);
        mwg_pkg::REG_STEP:  phase_step_r    <= pwdata;
        mwg_pkg::REG_AMP:   amplitude_r     <= pwdata[17:0];
        mwg_pkg::REG_DEPTH: depth_mode_r    <= pwdata[1:0];
        mwg_pkg::REG_TOTAL: total_samples_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      mwg_pkg::REG_WAVE:  prdata = {30'd0, wave_select_r};
      mwg_pkg::REG_STEP:  prdata = phase_step_r;
      mwg_pkg::REG_AMP:   prdata = {14'd0, amplitude_r};
      mwg_pkg::REG_DEPTH: prdata = {30'd0, depth_mode_r};
      mwg_pkg::REG_TOTAL: prdata = total_samples_r;
      default:            prdata = '0;
    endcase
  end

  // Pipeline valid bits and stage enables.
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, en5;
  logic accept;

  assign en5      = !out_valid_r || out_ready;
  assign en4      = !v4_r || en5;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign accept   = in_valid && in_ready;

  // Tick handling: phase accumulator and sample counter.
  logic [PHASE_BITS-1:0] phase_acc_r;
  logic [PHASE_BITS-1:0] phase_eff;
  logic [31:0]           sample_count_r;
  logic [31:0]           count_eff;
  logic                  emit;
  logic                  last_nxt;
  logic [31:0]           p32_nxt;

  assign phase_eff = in_restart ? '0 : phase_acc_r;
  assign count_eff = in_restart ? '0 : sample_count_r;
  assign emit      = count_eff < total_samples_r;
  assign last_nxt  = (33'(count_eff) + 33'd1) == 33'(total_samples_r);

  // The wave logic always looks at the top 32 phase bits.
  if (PHASE_BITS >= 32) begin : g_top_wide
    assign p32_nxt = phase_eff[PHASE_BITS-1 -: 32];
  end else begin : g_top_narrow
    assign p32_nxt = {phase_eff, {(32 - PHASE_BITS){1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_acc_r    <= '0;
      sample_count_r <= '0;
    end else if (accept) begin
      if (emit) begin
        phase_acc_r    <= phase_eff + PHASE_BITS'(phase_step_r);
        sample_count_r <= count_eff + 32'd1;
      end else begin
        phase_acc_r    <= phase_eff;
        sample_count_r <= count_eff;
      end
    end
  end

  // Stage 1: captured phase.
  logic [31:0] p32_r;
  logic        last1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      p32_r   <= p32_nxt;
      last1_r <= last_nxt;
    end
  end

  // Stage 1 to 2: wave shape as sign and Q30 magnitude; sine goes through the table.
  logic                    sine2_nxt;
  logic                    neg2_nxt;
  logic [30:0]             mag2_nxt;
  logic [SINE_ADDR_BITS-1:0] tab_addr;
  logic [SINE_ADDR_BITS:0]   tab_idx;
  logic [30:0]             p31;
  logic signed [33:0]      tri_w;
  logic [30:0]             rom_data;

  assign tab_addr = p32_r[29 -: SINE_ADDR_BITS];
  assign tab_idx  = p32_r[30] ? ((SINE_ADDR_BITS+1)'(TAB_N) - {1'b0, tab_addr})
                              : {1'b0, tab_addr};
  assign p31      = p32_r[31:1];

  always_comb begin
    sine2_nxt = 1'b0;
    neg2_nxt  = 1'b0;
    mag2_nxt  = '0;
    tri_w     = '0;
    case (wave_select_r)
      mwg_pkg::WAVE_SINE: begin
        // The sign is qualified by the table value once it is read.
        sine2_nxt = 1'b1;
        neg2_nxt  = p32_r[31];
      end
      mwg_pkg::WAVE_SAW: begin
        neg2_nxt = !p31[30];
        mag2_nxt = p31[30] ? {1'b0, p31[29:0]} : (mwg_pkg::ONE_Q30 - p31);
      end
      mwg_pkg::WAVE_SQUARE: begin
        neg2_nxt = p32_r[31];
        mag2_nxt = mwg_pkg::ONE_Q30;
      end
      mwg_pkg::WAVE_TRIANGLE: begin
        if (p32_r[31]) begin
          tri_w = 34'sh0_C000_0000 - signed'({2'b00, p32_r});
        end else begin
          tri_w = signed'({2'b00, p32_r}) - 34'sh0_4000_0000;
        end
        neg2_nxt = tri_w[33];
        mag2_nxt = tri_w[33] ? 31'(-tri_w) : 31'(tri_w);
      end
      default: ;
    endcase
  end

  mwg_sine_rom #(
    .SINE_ADDR_BITS(SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk    (clk),
    .rd_en  (en2),
    .rd_idx (tab_idx),
    .rd_data(rom_data)
  );

  // Stage 2: wave value.
  logic        sine2_r;
  logic        neg2_r;
  logic [30:0] mag2_r;
  logic        last2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sine2_r <= sine2_nxt;
      neg2_r  <= neg2_nxt;
      mag2_r  <= mag2_nxt;
      last2_r <= last1_r;
    end
  end

  // Stage 2 to 3: amplitude scaling with rounding and saturation at one.
  logic [30:0] mag_sel;
  logic        neg_sel;
  logic [49:0] amp_prod;
  logic [49:0] amp_scaled;
  logic [30:0] val3_nxt;

  assign mag_sel    = sine2_r ? rom_data : mag2_r;
  assign neg_sel    = sine2_r ? (neg2_r && (rom_data != '0)) : neg2_r;
  assign amp_prod   = 50'(mag_sel) * 50'(amplitude_r) + (50'd1 << (AMP_FRAC_BITS - 1));
  assign amp_scaled = amp_prod >> AMP_FRAC_BITS;
  assign val3_nxt   = (amp_scaled > 50'(mwg_pkg::ONE_Q30)) ? mwg_pkg::ONE_Q30
                                                           : amp_scaled[30:0];

  // Stage 3: scaled magnitude.
  logic        neg3_r;
  logic [30:0] val3_r;
  logic        last3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      neg3_r  <= neg_sel;
      val3_r  <= val3_nxt;
      last3_r <= last2_r;
    end
  end

  // Stage 3 to 4: conversion to the depth's full scale.
  logic [30:0] full_scale;
  logic [61:0] fs_prod;
  logic [30:0] s4_nxt;

  always_comb begin
    case (depth_mode_r)
      mwg_pkg::DEPTH_8:  full_scale = mwg_pkg::FS_8;
      mwg_pkg::DEPTH_32: full_scale = mwg_pkg::FS_32;
      default:           full_scale = mwg_pkg::FS_16;
    endcase
  end

  assign fs_prod = 62'(val3_r) * 62'(full_scale) + (62'd1 << 29);
  assign s4_nxt  = 31'(fs_prod >> 30);

  // Stage 4: full-scale magnitude.
  logic        neg4_r;
  logic [30:0] s4_r;
  logic        last4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en4) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      neg4_r  <= neg3_r;
      s4_r    <= s4_nxt;
      last4_r <= last3_r;
    end
  end

  // Stage 4 to output: sign, or the unsigned offset byte in eight-bit mode.
  // There (s + 127) * 255 / 254 only differs from s + 127 at the top code.
  logic [7:0]  byte_off;
  logic [31:0] sample_nxt;

  always_comb begin
    byte_off = neg4_r ? (8'd127 - s4_r[7:0]) : (8'd127 + s4_r[7:0]);
    if (depth_mode_r == mwg_pkg::DEPTH_8) begin
      sample_nxt = (byte_off == 8'd254) ? 32'd255 : {24'd0, byte_off};
    end else if (neg4_r) begin
      sample_nxt = -{1'b0, s4_r};
    end else begin
      sample_nxt = {1'b0, s4_r};
    end
  end

  logic [31:0] out_sample_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en5) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_sample_r <= sample_nxt;
      out_last_r   <= last4_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;
  assign out_last   = out_last_r;

endmodule

[tb/mwg_sample_checker.sv]
// ----------------------------------------------------------------------------
// mwg_sample_checker
// Watches the generator's tick, sample and register ports, predicts every
// sample and compares it with the one the generator delivers.
// ----------------------------------------------------------------------------
module mwg_sample_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_restart,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_sample,
  input  logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending,
  output int          samples_seen
);
  import mwg_pkg::*;

  localparam int     ADDR_BITS = SINE_ADDR_BITS_DEF;
  localparam int     FRAC_BITS = AMP_FRAC_BITS_DEF;
  localparam int     TAB_N     = 1 << ADDR_BITS;
  localparam longint Q30_UNIT  = 64'sd1 << 30;

  typedef struct packed {
    logic [31:0] sample;
    logic        last;
  } pcm_t;

  logic [30:0] sine_quarter [0:TAB_N];

  wave_t       cfg_wave;
  logic [31:0] cfg_step;
  logic [17:0] cfg_amp;
  logic [1:0]  cfg_depth;
  logic [31:0] cfg_total;

  logic [31:0] phase;
  logic [31:0] count;
  pcm_t        expected_samples [$];

  // Integer Taylor series of sin(x) for x in Q30, cut after the x^17 term.
  function automatic logic [30:0] taylor_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    longint      acc;
    x2 = (x * x) >> 30;
    term = x;
    acc = longint'(x);
    for (int i = 1; i <= 8; i++) begin
      term = ((term * x2) >> 30) / 64'((2 * i) * (2 * i + 1));
      if (i % 2 == 1) begin
        acc -= longint'(term);
      end else begin
        acc += longint'(term);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > Q30_UNIT) acc = Q30_UNIT;
    return 31'(acc);
  endfunction

  // Signed wave value in Q30 for the current wave selection.
  function automatic longint wave_value(input logic [31:0] ph);
    logic [1:0]           quad;
    logic [ADDR_BITS-1:0] addr;
    int                   idx;
    longint               mag;
    case (cfg_wave)
      WAVE_SINE: begin
        quad = ph[31:30];
        addr = ph[29 -: ADDR_BITS];
        idx = quad[0] ? TAB_N - int'(addr) : int'(addr);
        mag = longint'({33'b0, sine_quarter[idx]});
        return quad[1] ? -mag : mag;
      end
      WAVE_SAW: return longint'({33'b0, ph[31:1]}) - Q30_UNIT;
      WAVE_SQUARE: return ph[31] ? -Q30_UNIT : Q30_UNIT;
      default: begin
        mag = longint'({32'b0, ph});
        return ph[31] ? 3 * Q30_UNIT - mag : mag - Q30_UNIT;
      end
    endcase
  endfunction

  // Amplitude scaling, rounding to full scale and the 8-bit offset mapping.
  function automatic logic [31:0] scale_sample(input longint w);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] fs;
    logic [63:0] v;
    logic [63:0] s;
    longint      si;
    neg = w < 0;
    mag = neg ? -w : w;
    case (cfg_depth)
      DEPTH_8:  fs = 64'(FS_8);
      DEPTH_32: fs = 64'(FS_32);
      default:  fs = 64'(FS_16);
    endcase
    v = (mag * cfg_amp + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (v > (64'd1 << 30)) v = 64'd1 << 30;
    s = (v * fs + (64'd1 << 29)) >> 30;
    if (cfg_depth == DEPTH_8) begin
      si = neg ? -longint'(s) : longint'(s);
      return 32'((si + 127) * 255 / 254);
    end
    return neg ? 32'd0 - s[31:0] : s[31:0];
  endfunction

  initial begin
    for (int k = 0; k <= TAB_N; k++) begin
      sine_quarter[k] = taylor_sine((64'(k) * HALF_PI_Q30) >> ADDR_BITS);
    end
  end

  always @(posedge clk) begin : watch
    pcm_t want;
    if (!rst_n) begin
      cfg_wave  = WAVE_SINE;
      cfg_step  = '0;
      cfg_amp   = 18'd65536;
      cfg_depth = DEPTH_16;
      cfg_total = '0;
      phase     = '0;
      count     = '0;
      expected_samples.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_WAVE:  cfg_wave  = wave_t'(pwdata[1:0]);
          REG_STEP:  cfg_step  = pwdata;
          REG_AMP:   cfg_amp   = pwdata[17:0];
          REG_DEPTH: cfg_depth = pwdata[1:0];
          REG_TOTAL: cfg_total = pwdata;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        if (in_restart) begin
          phase = '0;
          count = '0;
        end
        // A finished run leaves phase and count untouched.
        if (count < cfg_total) begin
          want.sample = scale_sample(wave_value(phase));
          want.last = ({1'b0, count} + 33'd1) == {1'b0, cfg_total};
          count = count + 32'd1;
          phase = phase + cfg_step;
          expected_samples.push_back(want);
        end
      end

      if (out_valid && out_ready) begin
        if (expected_samples.size() == 0) begin
          errors++;
          $error("sample: expected none, got %h (last %b)", out_sample, out_last);
        end else begin
          want = expected_samples.pop_front();
          samples_seen++;
          if (out_sample !== want.sample) begin
            errors++;
            $error("sample: expected %h, got %h", want.sample, out_sample);
          end
          if (out_last !== want.last) begin
            errors++;
            $error("last: expected %b, got %b", want.last, out_last);
          end
        end
      end
    end
    pending = expected_samples.size();
  end

endmodule

[tb/multi_waveform_generator_top_test.sv]
// ----------------------------------------------------------------------------
// multi_waveform_generator_top_test
// Drives ticks and register writes into the waveform generator and gives the
// verdict; the sample checker beside the block predicts and compares samples.
// ----------------------------------------------------------------------------
module multi_waveform_generator_top_test;
  import mwg_pkg::*;

  localparam int         CYCLE_LIMIT   = 300000;
  localparam int         DRAIN_CYCLES  = 12;
  localparam int         LONG_HOLD     = 400;
  localparam int         RANDOM_PHASES = 16;
  localparam int         PHASE_TICKS   = 100;
  // Depth code three is not named in the package; the block treats it as 16-bit.
  localparam logic [1:0] DEPTH_SPARE   = 2'd3;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_restart = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic        out_ready  = 1'b0;
  logic [31:0] out_sample;
  logic        out_last;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [4:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  logic [31:0] prdata;
  logic        pready;

  int errors;
  int pending;
  int samples_seen;
  int tx_gap_pct     = 0;
  int rx_stall_pct   = 0;
  int hold_reqs      = 0;
  int ticks_sent     = 0;
  int settings_used  = 0;

  multi_waveform_generator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_sample (out_sample),
    .out_last   (out_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mwg_sample_checker u_sample_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_sample   (out_sample),
    .out_last     (out_last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .errors       (errors),
    .pending      (pending),
    .samples_seen (samples_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // Sample sink: random stalls, plus a long hold-off whenever one is requested.
  initial begin : sink
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_served) begin
        holds_served = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // All tasks start and end right after a rising edge.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input wave_t wave, input logic [31:0] step,
                               input logic [17:0] amp, input logic [1:0] depth,
                               input logic [31:0] total);
    write_reg(REG_WAVE, 32'(wave));
    write_reg(REG_STEP, step);
    write_reg(REG_AMP, 32'(amp));
    write_reg(REG_DEPTH, 32'(depth));
    write_reg(REG_TOTAL, total);
    settings_used++;
  endtask

  task automatic send_tick(input logic restart);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    ticks_sent++;
  endtask

  // Stops the ticks until every predicted sample has been delivered, then lets
  // the pipeline settle so a late sample with no prediction would still show.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic directed_run(input wave_t wave, input logic [17:0] amp,
                              input logic [1:0] depth);
    apply_setting(wave, 32'h2000_0000, amp, depth, 32'd5);
    send_tick(1'b1);
    repeat (4) send_tick(1'b0);
    // The run of five is over, so this transaction yields nothing.
    send_tick(1'b0);
    drain_results();
  endtask

  initial begin : stimulus
    logic [31:0] step_val;
    logic [17:0] amp_val;
    logic [31:0] total_val;
    int          sel;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset total_samples is zero, so nothing comes out.
    send_tick(1'b1);
    drain_results();

    directed_run(WAVE_SINE, 18'd65536, DEPTH_32);
    directed_run(WAVE_SAW, 18'd65536, DEPTH_8);
    directed_run(WAVE_SQUARE, 18'h3FFFF, DEPTH_16);
    directed_run(WAVE_TRIANGLE, 18'd40000, DEPTH_SPARE);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      sel = (ph < 3) ? ph : 3;
      case (sel)
        0: begin
          step_val = 32'hFFFF_FFFF;
          amp_val = 18'd0;
          total_val = 32'hFFFF_FFFF;
        end
        1: begin
          step_val = 32'd0;
          amp_val = 18'h3FFFF;
          total_val = 32'd1;
        end
        2: begin
          step_val = 32'h8000_0000;
          amp_val = 18'd65536;
          total_val = 32'd0;
        end
        default: begin
          step_val = $urandom_range(1) ? $urandom : $urandom_range(32'h0040_0000);
          amp_val = $urandom_range(1) ? 18'($urandom) : 18'($urandom_range(65536));
          total_val = $urandom_range(160, 8);
        end
      endcase
      apply_setting(wave_t'($urandom_range(3)), step_val, amp_val,
                    2'($urandom_range(3)), total_val);

      case (ph % 4)
        0: begin
          tx_gap_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_gap_pct = 59;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_gap_pct = 0;
          rx_stall_pct <= 59;
        end
        default: begin
          tx_gap_pct = 15;
          rx_stall_pct <= 15;
        end
      endcase
      // The sink holds off for a long while so the pipeline backs up.
      if (ph == 4) hold_reqs <= hold_reqs + 1;

      for (int t = 0; t < PHASE_TICKS; t++) begin
        if (ph == 6 && t == PHASE_TICKS / 2) drain_results();
        // Odd phases keep the count of the previous setting on their first tick.
        send_tick(t == 0 ? (ph % 2 == 0) : ($urandom_range(99) < 4));
      end
      drain_results();
    end

    $display("Sent %0d ticks under %0d register settings and checked %0d samples.",
             ticks_sent, settings_used, samples_seen);
    $display("%s%s", "All four waveforms, every depth code, extreme steps and amplitudes, ",
             "and sink back-pressure were exercised.");
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
